// ===== rtl/stack_unwind_bytecode_executor_assert.svh =====
// Assertion macros shared by the unwind executor RTL.
// Depends on nothing; included by the modules that carry checks.
`ifndef STACK_UNWIND_BYTECODE_EXECUTOR_ASSERT_SVH
`define STACK_UNWIND_BYTECODE_EXECUTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SUBE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("unwind executor check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SUBE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("unwind executor check failed");

`endif

// ===== rtl/sube_pkg.sv =====
// Package for the unwind executor: beat payloads, codes and shared structs.
// Depends on nothing; used by every other file of the block but the assertion header.
package sube_pkg;

    // Item modes.
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_OPCODE = 2'd1;
    localparam logic [1:0] MODE_STACK  = 2'd2;
    localparam logic [1:0] MODE_END    = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_WAIT    = 3'd1;
    localparam logic [2:0] ST_REFUSED = 3'd2;
    localparam logic [2:0] ST_FAIL    = 3'd3;
    localparam logic [2:0] ST_DONE    = 3'd4;

    // Register numbers with a fixed role.
    localparam logic [3:0] R_FP = 4'd7;
    localparam logic [3:0] R_SP = 4'd13;
    localparam logic [3:0] R_LR = 4'd14;
    localparam logic [3:0] R_PC = 4'd15;

    // Opcode values.
    localparam logic [7:0] OP_FINISH      = 8'hb0;
    localparam logic [7:0] OP_POP_LOW     = 8'hb1;
    localparam logic [7:0] OP_SP_ADD_LONG = 8'hb2;
    localparam logic [7:0] OP_SPARE_C7    = 8'hc7;
    localparam logic [7:0] OP_SET_SP_R13  = 8'h9d;
    localparam logic [7:0] OP_SET_SP_R15  = 8'h9f;
    localparam logic [31:0] SP_LONG_BASE  = 32'h0000_0204;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SECOND,
        PH_POP,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  reg_index;
        logic [31:0] data_word;
        logic [7:0]  opcode_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic        read_request;
        logic [31:0] read_address;
        logic [31:0] pc_value;
        logic [31:0] lr_value;
        logic [31:0] sp_value;
        logic [31:0] fp_value;
    } t_out_item;

    // Register file write request: one general port and one for vsp.
    typedef struct packed {
        logic        a_en;
        logic [3:0]  a_addr;
        logic [31:0] a_data;
        logic        sp_en;
        logic [31:0] sp_data;
    } t_rf_write;

    // Current register values the step logic reads.
    typedef struct packed {
        logic [31:0] pc;
        logic [31:0] lr;
        logic [31:0] sp;
        logic [31:0] sel;
    } t_rf_view;

    // Register values after the pending write, for the result.
    typedef struct packed {
        logic [31:0] pc;
        logic [31:0] lr;
        logic [31:0] sp;
        logic [31:0] fp;
    } t_rf_taps;

    typedef struct packed {
        logic [2:0]  status;
        logic        read_request;
        logic [31:0] read_address;
    } t_exec_result;

endpackage

// ===== rtl/sube_if.sv =====
// Valid/ready channel interfaces for input items and result items.
// Depends on sube_pkg for the beat payload types.
interface sube_in_if;
    sube_pkg::t_in_item data;
    logic               valid;
    logic               ready;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sube_out_if;
    sube_pkg::t_out_item data;
    logic                valid;
    logic                ready;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/sube_regfile.sv =====
// Sixteen-entry virtual register file with a general and a vsp write port.
// Depends on sube_pkg for the write, view and tap structs.
module sube_regfile (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sube_pkg::t_rf_write i_wr,
    input  logic [3:0]          i_sel_addr,
    output sube_pkg::t_rf_view  o_view,
    output sube_pkg::t_rf_taps  o_next
);
    import sube_pkg::*;

    logic [31:0] r_regs [16];
    logic [31:0] n_regs [16];

    // Merge the two write ports; the vsp port wins on r13.
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            n_regs[i] = r_regs[i];
            if (i_wr.sp_en && (4'(i) == R_SP)) begin
                n_regs[i] = i_wr.sp_data;
            end else if (i_wr.a_en && (i_wr.a_addr == 4'(i))) begin
                n_regs[i] = i_wr.a_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 16; i++) begin
            if (!i_rst_n) begin
                r_regs[i] <= '0;
            end else begin
                r_regs[i] <= n_regs[i];
            end
        end
    end

    // Current values for the step logic.
    assign o_view.pc  = r_regs[R_PC];
    assign o_view.lr  = r_regs[R_LR];
    assign o_view.sp  = r_regs[R_SP];
    assign o_view.sel = r_regs[i_sel_addr];

    // Values after this cycle's write, captured into the result beat.
    assign o_next.pc = n_regs[R_PC];
    assign o_next.lr = n_regs[R_LR];
    assign o_next.sp = n_regs[R_SP];
    assign o_next.fp = n_regs[R_FP];

endmodule

// ===== rtl/sube_exec.sv =====
// Unwind step logic: opcode decode, pop sequencing and control state.
// Depends on sube_pkg and the assertion macro header.
`include "stack_unwind_bytecode_executor_assert.svh"

module sube_exec (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  sube_pkg::t_in_item     i_item,
    input  sube_pkg::t_rf_view     i_view,
    output logic [3:0]             o_sel_addr,
    output sube_pkg::t_rf_write    o_wr,
    output sube_pkg::t_exec_result o_result
);
    import sube_pkg::*;

    t_phase      r_phase;
    t_phase      n_phase;
    logic [7:0]  r_first_byte;
    logic [7:0]  n_first_byte;
    logic [15:0] r_pop_mask;
    logic [15:0] n_pop_mask;
    logic [31:0] r_pop_address;
    logic [31:0] n_pop_address;
    logic        r_sp_deferred;
    logic        n_sp_deferred;
    logic        r_failed;
    logic        n_failed;

    logic        w_stopped;
    logic        w_refused;
    logic        w_start_pop;
    logic [15:0] w_pop_bits;
    logic [7:0]  w_byte;
    logic [7:0]  w_held;
    logic [11:0] w_mask12;
    logic [7:0]  w_range;
    logic [7:0]  w_short;
    logic        w_low_any;
    logic [3:0]  w_low_idx;
    logic [15:0] w_mask_left;
    logic        w_defer;
    logic [31:0] w_addr_step;
    logic        w_req;

    assign w_byte     = i_item.opcode_byte;
    assign w_held     = r_first_byte;
    assign w_mask12   = {w_held[3:0], w_byte};
    assign w_range    = 8'hff >> (3'd7 - w_byte[2:0]);
    assign w_short    = {w_byte[5:0], 2'b00};
    assign w_stopped  = r_failed || (r_phase == PH_DONE);
    assign o_sel_addr = w_byte[3:0];

    // Lowest register still waiting to be popped.
    always_comb begin
        w_low_any = 1'b0;
        w_low_idx = '0;
        for (int i = 15; i >= 0; i--) begin
            if (r_pop_mask[i]) begin
                w_low_any = 1'b1;
                w_low_idx = 4'(i);
            end
        end
    end

    assign w_mask_left = r_pop_mask & ~(16'd1 << w_low_idx);
    assign w_defer     = r_sp_deferred || (w_low_idx == R_SP);
    assign w_addr_step = r_pop_address + 32'd4;

    // Next state and register file writes for the item in the execute stage.
    always_comb begin
        n_phase       = r_phase;
        n_first_byte  = r_first_byte;
        n_pop_mask    = r_pop_mask;
        n_pop_address = r_pop_address;
        n_sp_deferred = r_sp_deferred;
        n_failed      = r_failed;
        w_refused     = 1'b0;
        w_start_pop   = 1'b0;
        w_pop_bits    = '0;
        o_wr          = '0;

        if (i_fire) begin
            case (i_item.mode)
                MODE_LOAD: begin
                    o_wr.a_en   = 1'b1;
                    o_wr.a_addr = i_item.reg_index;
                    o_wr.a_data = i_item.data_word;
                end
                MODE_OPCODE: begin
                    if (!w_stopped && (r_phase == PH_IDLE)) begin
                        // First byte of an instruction.
                        if (w_byte[7:6] == 2'b00) begin
                            o_wr.sp_en   = 1'b1;
                            o_wr.sp_data = i_view.sp + {24'd0, w_short} + 32'd4;
                        end else if (w_byte[7:6] == 2'b01) begin
                            o_wr.sp_en   = 1'b1;
                            o_wr.sp_data = i_view.sp - ({24'd0, w_short} + 32'd4);
                        end else if ((w_byte[7:4] == 4'h8) || (w_byte == OP_POP_LOW) ||
                                     (w_byte == OP_SP_ADD_LONG) ||
                                     (w_byte == OP_SPARE_C7)) begin
                            n_first_byte = w_byte;
                            n_phase      = PH_SECOND;
                        end else if ((w_byte[7:4] == 4'h9) && (w_byte != OP_SET_SP_R13) &&
                                     (w_byte != OP_SET_SP_R15)) begin
                            o_wr.sp_en   = 1'b1;
                            o_wr.sp_data = i_view.sel;
                        end else if (w_byte[7:4] == 4'ha) begin
                            w_start_pop = 1'b1;
                            w_pop_bits  = {1'b0, w_byte[3], 2'b00, w_range, 4'h0};
                        end else if (w_byte == OP_FINISH) begin
                            if (i_view.pc == '0) begin
                                o_wr.a_en   = 1'b1;
                                o_wr.a_addr = R_PC;
                                o_wr.a_data = i_view.lr;
                            end
                        end else begin
                            n_failed = 1'b1;
                        end
                    end else if (!w_stopped && (r_phase == PH_SECOND)) begin
                        // Second byte of a two-byte instruction.
                        n_phase = PH_IDLE;
                        if (w_held[7:4] == 4'h8) begin
                            if (w_mask12 == '0) begin
                                n_failed  = 1'b1;
                                w_refused = 1'b1;
                            end else begin
                                w_start_pop = 1'b1;
                                w_pop_bits  = {w_mask12, 4'h0};
                            end
                        end else if (w_held == OP_POP_LOW) begin
                            if ((w_byte == '0) || (w_byte[7:4] != 4'h0)) begin
                                n_failed = 1'b1;
                            end else begin
                                w_start_pop = 1'b1;
                                w_pop_bits  = {8'd0, w_byte};
                            end
                        end else if (w_held == OP_SP_ADD_LONG) begin
                            o_wr.sp_en   = 1'b1;
                            o_wr.sp_data = i_view.sp + SP_LONG_BASE + {22'd0, w_byte, 2'b00};
                        end else begin
                            if ((w_byte == '0) || (w_byte[7:4] != 4'h0)) begin
                                n_failed = 1'b1;
                            end
                        end
                    end
                end
                MODE_STACK: begin
                    if (!w_stopped && (r_phase == PH_POP)) begin
                        if (!w_low_any) begin
                            n_phase = PH_IDLE;
                        end else begin
                            o_wr.a_en     = 1'b1;
                            o_wr.a_addr   = w_low_idx;
                            o_wr.a_data   = i_item.data_word;
                            n_pop_mask    = w_mask_left;
                            n_pop_address = w_addr_step;
                            n_sp_deferred = w_defer;
                            if (w_mask_left == '0) begin
                                // Last pop: vsp moves past the block unless r13 was popped.
                                if (!w_defer) begin
                                    o_wr.sp_en   = 1'b1;
                                    o_wr.sp_data = w_addr_step;
                                end
                                n_sp_deferred = 1'b0;
                                n_phase       = PH_IDLE;
                            end
                        end
                    end
                end
                MODE_END: begin
                    if (!w_stopped) begin
                        if (r_phase == PH_POP) begin
                            n_failed = 1'b1;
                        end else begin
                            if (i_view.pc == '0) begin
                                o_wr.a_en   = 1'b1;
                                o_wr.a_addr = R_PC;
                                o_wr.a_data = i_view.lr;
                            end
                            n_phase = PH_DONE;
                        end
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase

            // Start of a pop sequence at the current vsp.
            if (w_start_pop) begin
                n_pop_mask    = w_pop_bits;
                n_pop_address = i_view.sp;
                n_sp_deferred = 1'b0;
                n_phase       = (w_pop_bits != '0) ? PH_POP : PH_IDLE;
            end
        end
    end

    // Result status from the state after this step.
    assign w_req = (n_phase == PH_POP) && !n_failed;

    always_comb begin
        if (w_refused) begin
            o_result.status = ST_REFUSED;
        end else if (n_failed) begin
            o_result.status = ST_FAIL;
        end else if (n_phase == PH_DONE) begin
            o_result.status = ST_DONE;
        end else if (n_phase == PH_POP) begin
            o_result.status = ST_WAIT;
        end else begin
            o_result.status = ST_OK;
        end
        o_result.read_request = w_req;
        o_result.read_address = w_req ? n_pop_address : '0;
    end

    // Control state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_first_byte  <= '0;
            r_pop_mask    <= '0;
            r_pop_address <= '0;
            r_sp_deferred <= 1'b0;
            r_failed      <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_first_byte  <= n_first_byte;
            r_pop_mask    <= n_pop_mask;
            r_pop_address <= n_pop_address;
            r_sp_deferred <= n_sp_deferred;
            r_failed      <= n_failed;
        end
    end

    // A pop in progress always has a register left to pop.
    `SUBE_ASSERT_IMP(a_pop_has_mask, i_clk, i_rst_n, r_phase == PH_POP, r_pop_mask != '0)
    // Failure is sticky until reset.
    `SUBE_ASSERT_NXT(a_failed_sticky, i_clk, i_rst_n, r_failed, r_failed)
    // Once the stream has completed it stays completed.
    `SUBE_ASSERT_NXT(a_done_sticky, i_clk, i_rst_n, r_phase == PH_DONE, r_phase == PH_DONE)
    // A deferred vsp only exists while a pop is running.
    `SUBE_ASSERT_IMP(a_defer_in_pop, i_clk, i_rst_n, r_sp_deferred, r_phase == PH_POP)
    // The two write ports never race on r13.
    `SUBE_ASSERT_IMP(a_no_sp_clash, i_clk, i_rst_n, o_wr.sp_en && o_wr.a_en, o_wr.a_addr != R_SP)

endmodule

// ===== rtl/stack_unwind_bytecode_executor.sv =====
// Top level of the unwind executor: input stage, step logic, result register.
// Depends on sube_pkg, sube_if, sube_regfile and sube_exec.
//
//  channel | direction | beat contents
//  i_in    | sink      | mode, reg_index, data_word, opcode_byte
//  o_out   | source    | status, read_request, read_address, pc/lr/sp/fp values
//
// One item is accepted per cycle while the result side takes its beats; its result
// passes through the input register and then the result register.
// The step logic decodes the item, does its 32-bit adds and writes the register file.
// Reset is synchronous, active low, and clears the register file, valids and control state.
// A stalled result holds in the result register; an empty input register still takes a beat.
module stack_unwind_bytecode_executor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sube_in_if.sink    i_in,
    sube_out_if.source o_out
);
    import sube_pkg::*;

    logic         r_in_valid;
    t_in_item     r_in_item;
    logic         r_out_valid;
    t_out_item    r_out_item;
    logic         w_fire;
    logic [3:0]   w_sel_addr;
    t_rf_write    w_wr;
    t_rf_view     w_view;
    t_rf_taps     w_next;
    t_exec_result w_result;

    // The execute stage advances when the result register is free or draining.
    assign w_fire     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_fire;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_item <= i_in.data;
        end
    end

    sube_regfile u_regfile (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (w_wr),
        .i_sel_addr (w_sel_addr),
        .o_view     (w_view),
        .o_next     (w_next)
    );

    sube_exec u_exec (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_fire),
        .i_item     (r_in_item),
        .i_view     (w_view),
        .o_sel_addr (w_sel_addr),
        .o_wr       (w_wr),
        .o_result   (w_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_fire || (r_out_valid && !o_out.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_item.status       <= w_result.status;
            r_out_item.read_request <= w_result.read_request;
            r_out_item.read_address <= w_result.read_address;
            r_out_item.pc_value     <= w_next.pc;
            r_out_item.lr_value     <= w_next.lr;
            r_out_item.sp_value     <= w_next.sp;
            r_out_item.fp_value     <= w_next.fp;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_item;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the unwind opcode executor: a shadow model predicts every result beat.
// Depends on sube_pkg, sube_if and the stack_unwind_bytecode_executor RTL.

import sube_pkg::*;

// Shadow copy of the executor state; it predicts the snapshot each input beat produces.
class unwind_shadow;
    logic [31:0] vregs [16];
    logic [7:0]  held_byte;
    t_phase      phase;
    logic [15:0] pop_left;
    logic [31:0] pop_addr;
    bit          sp_popped;
    bit          faulted;
    t_out_item   awaited[$];
    int          mismatches;
    int          results_seen;

    function new();
        foreach (vregs[k]) vregs[k] = '0;
        held_byte    = '0;
        phase        = PH_IDLE;
        pop_left     = '0;
        pop_addr     = '0;
        sp_popped    = 1'b0;
        faulted      = 1'b0;
        mismatches   = 0;
        results_seen = 0;
    endfunction

    function logic [2:0] status_now();
        if (faulted) return ST_FAIL;
        if (phase == PH_DONE) return ST_DONE;
        if (phase == PH_POP) return ST_WAIT;
        return ST_OK;
    endfunction

    function void begin_pop(logic [15:0] bits);
        pop_left  = bits;
        pop_addr  = vregs[R_SP];
        sp_popped = 1'b0;
        phase     = (bits != '0) ? PH_POP : PH_IDLE;
    endfunction

    function void pc_from_lr();
        if (vregs[R_PC] == '0) vregs[R_PC] = vregs[R_LR];
    endfunction

    // Advance the shadow state by one accepted input beat and queue the expected snapshot.
    function void apply_item(t_in_item it);
        t_out_item   snap;
        logic [7:0]  op;
        logic [2:0]  st;
        logic [11:0] mask12;
        logic [15:0] bits;
        bit          refused;
        int          low;
        op      = it.opcode_byte;
        refused = 1'b0;
        if (it.mode == MODE_LOAD) begin
            // Loads land in any phase, even after a failure or the end.
            vregs[it.reg_index] = it.data_word;
            st = status_now();
        end else if (faulted || phase == PH_DONE) begin
            st = status_now();
        end else if (it.mode == MODE_OPCODE && phase == PH_IDLE) begin
            if (op[7:6] == 2'b00) begin
                vregs[R_SP] = vregs[R_SP] + {24'd0, op[5:0], 2'b00} + 32'd4;
            end else if (op[7:6] == 2'b01) begin
                vregs[R_SP] = vregs[R_SP] - ({24'd0, op[5:0], 2'b00} + 32'd4);
            end else if (op[7:4] == 4'h8 || op == OP_POP_LOW || op == OP_SP_ADD_LONG
                         || op == OP_SPARE_C7) begin
                held_byte = op;
                phase     = PH_SECOND;
            end else if (op[7:4] == 4'h9 && op != OP_SET_SP_R13 && op != OP_SET_SP_R15) begin
                vregs[R_SP] = vregs[op[3:0]];
            end else if (op[7:4] == 4'ha) begin
                bits = 16'(((32'd1 << (op[2:0] + 32'd1)) - 32'd1) << 4);
                if (op[3]) bits[R_LR] = 1'b1;
                begin_pop(bits);
            end else if (op == OP_FINISH) begin
                pc_from_lr();
            end else begin
                faulted = 1'b1;
            end
            st = status_now();
        end else if (it.mode == MODE_OPCODE && phase == PH_SECOND) begin
            phase = PH_IDLE;
            if (held_byte[7:4] == 4'h8) begin
                mask12 = {held_byte[3:0], op};
                if (mask12 == '0) begin
                    faulted = 1'b1;
                    refused = 1'b1;
                end else begin
                    begin_pop({mask12, 4'b0000});
                end
            end else if (held_byte == OP_SP_ADD_LONG) begin
                vregs[R_SP] = vregs[R_SP] + SP_LONG_BASE + {22'd0, op, 2'b00};
            end else if (op == '0 || op[7:4] != 4'h0) begin
                // The low-register pop and the spare opcode both want 0000iiii with i nonzero.
                faulted = 1'b1;
            end else if (held_byte == OP_POP_LOW) begin
                begin_pop({8'd0, op});
            end
            st = refused ? ST_REFUSED : status_now();
        end else if (it.mode == MODE_STACK) begin
            // A stack word fills the lowest register still waiting; otherwise it is dropped.
            if (phase == PH_POP) begin
                low = 16;
                for (int k = 15; k >= 0; k--) begin
                    if (pop_left[k]) low = k;
                end
                if (low == 16) begin
                    phase = PH_IDLE;
                end else begin
                    vregs[low] = it.data_word;
                    if (low == R_SP) sp_popped = 1'b1;
                    pop_left[low] = 1'b0;
                    pop_addr      = pop_addr + 32'd4;
                    if (pop_left == '0) begin
                        if (!sp_popped) vregs[R_SP] = pop_addr;
                        sp_popped = 1'b0;
                        phase     = PH_IDLE;
                    end
                end
            end
            st = status_now();
        end else if (it.mode == MODE_END) begin
            if (phase == PH_POP) begin
                faulted = 1'b1;
            end else begin
                pc_from_lr();
                phase = PH_DONE;
            end
            st = status_now();
        end else begin
            // An opcode while a pop is pending is dropped.
            st = status_now();
        end
        snap.status       = st;
        snap.read_request = (phase == PH_POP) && !faulted;
        snap.read_address = snap.read_request ? pop_addr : '0;
        snap.pc_value     = vregs[R_PC];
        snap.lr_value     = vregs[R_LR];
        snap.sp_value     = vregs[R_SP];
        snap.fp_value     = vregs[R_FP];
        awaited.push_back(snap);
    endfunction

    function string show(t_out_item r);
        return $sformatf("status=%0d req=%0d addr=%h pc=%h lr=%h sp=%h fp=%h", r.status,
                         r.read_request, r.read_address, r.pc_value, r.lr_value, r.sp_value,
                         r.fp_value);
    endfunction

    // Compare one result beat with the oldest awaited snapshot.
    function void compare_snapshot(t_out_item got);
        t_out_item want;
        bit        bad;
        results_seen++;
        if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result %0d: %s", results_seen, show(got));
            return;
        end
        want = awaited.pop_front();
        bad = (got.status !== want.status) || (got.read_request !== want.read_request)
            || (got.read_address !== want.read_address) || (got.pc_value !== want.pc_value)
            || (got.lr_value !== want.lr_value) || (got.sp_value !== want.sp_value)
            || (got.fp_value !== want.fp_value);
        if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Mismatch on result %0d", results_seen);
                $display("  expected %s", show(want));
                $display("  actual   %s", show(got));
            end
        end
    endfunction
endclass

module testbench;
    localparam int HOLD_CYCLES = 60;
    localparam int STALL_LIMIT = 1000;
    localparam int PHASE_ITEMS = 600;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    sube_in_if    in_if ();
    sube_out_if   out_if ();
    unwind_shadow shadow;
    int           send_idle_pct;
    int           recv_idle_pct;
    bit           hold_request;
    int           beats_sent;
    int           ignored_beats;
    int           accepted_items;
    int           quiet_cycles;
    string        stream_end;

    stack_unwind_bytecode_executor u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Observe both channels at the rising edge; the watchdog counts edges with no beat moved.
    always @(posedge i_clk) begin : monitor
        bit moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                shadow.apply_item(in_if.data);
                accepted_items++;
                moved = 1'b1;
            end
            if (out_if.valid && out_if.ready) begin
                shadow.compare_snapshot(out_if.data);
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Watchdog: no beat moved for %0d cycles", STALL_LIMIT);
                $display("testbench failed");
                $finish;
            end
        end
    end

    // Result side: random back-pressure, plus one long hold-off when asked for.
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offer one beat, after a random gap, and hold it until the block takes it.
    task automatic send_item(t_in_item it);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.data  <= it;
        in_if.valid <= 1'b1;
        do @(posedge i_clk); while (!in_if.ready);
        @(negedge i_clk);
        beats_sent++;
    endtask

    // Unused fields of every beat carry random bits.
    function automatic t_in_item fresh(logic [1:0] mode);
        t_in_item it;
        it.mode        = mode;
        it.reg_index   = 4'($urandom);
        it.data_word   = $urandom;
        it.opcode_byte = 8'($urandom);
        return it;
    endfunction

    function automatic logic [31:0] edgy_word();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return 32'hffff_ff00 | 32'($urandom_range(255));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_load(logic [3:0] idx, logic [31:0] value);
        t_in_item it;
        it           = fresh(MODE_LOAD);
        it.reg_index = idx;
        it.data_word = value;
        send_item(it);
    endtask

    task automatic send_op(logic [7:0] op);
        t_in_item it;
        it             = fresh(MODE_OPCODE);
        it.opcode_byte = op;
        send_item(it);
    endtask

    task automatic send_word(logic [31:0] w);
        t_in_item it;
        it           = fresh(MODE_STACK);
        it.data_word = w;
        send_item(it);
    endtask

    task automatic send_end();
        send_item(fresh(MODE_END));
    endtask

    // Answer a pop with its stack words, now and then mixing in a dropped opcode or a load.
    task automatic feed_words(int count);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(99) < 6) begin
                send_op(8'($urandom));
                ignored_beats++;
            end
            if ($urandom_range(99) < 4) send_load(4'($urandom), edgy_word());
            send_word(edgy_word());
        end
    endtask

    // One well-formed opcode (with its stack words) or a load; now and then one stray stack word.
    task automatic random_step();
        int          pick;
        int          n;
        logic [7:0]  op;
        logic [11:0] mask;
        pick = $urandom_range(99);
        if (pick < 12) begin
            send_load(4'($urandom), edgy_word());
        end else if (pick < 30) begin
            send_op({2'b00, 6'($urandom)});
        end else if (pick < 45) begin
            send_op({2'b01, 6'($urandom)});
        end else if (pick < 52) begin
            do n = $urandom_range(15); while (n == R_SP || n == R_PC);
            send_op({4'h9, 4'(n)});
        end else if (pick < 64) begin
            op = {4'ha, 4'($urandom)};
            send_op(op);
            feed_words(int'(op[2:0]) + 1 + int'(op[3]));
        end else if (pick < 68) begin
            send_op(OP_FINISH);
        end else if (pick < 80) begin
            mask = ($urandom_range(19) == 0) ? 12'hfff : 12'($urandom);
            if (mask == '0) mask = 12'h200;
            send_op({4'h8, mask[11:8]});
            send_op(mask[7:0]);
            feed_words($countones(mask));
        end else if (pick < 86) begin
            op = 8'($urandom_range(15, 1));
            send_op(OP_POP_LOW);
            send_op(op);
            feed_words($countones(op));
        end else if (pick < 91) begin
            send_op(OP_SP_ADD_LONG);
            send_op(8'($urandom));
        end else if (pick < 95) begin
            send_op(OP_SPARE_C7);
            send_op(8'($urandom_range(15, 1)));
        end else begin
            send_word($urandom);
            ignored_beats++;
        end
    endtask

    task automatic run_random(int goal);
        int target;
        target = beats_sent - ignored_beats + goal;
        while (beats_sent - ignored_beats < target) random_step();
    endtask

    // Stop offering beats until every awaited result has come back.
    task automatic drain();
        in_if.valid <= 1'b0;
        do @(negedge i_clk); while (shadow.awaited.size() != 0);
    endtask

    task automatic set_profile(int send_pct, int recv_pct, bit hold);
        @(posedge i_clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        hold_request  = hold;
        @(negedge i_clk);
    endtask

    // The stream can only stop once per run, so the seed picks how it stops.
    task automatic finish_stream();
        logic [7:0] op;
        case ($urandom_range(5))
            0: begin
                stream_end = "a refused pop";
                send_op(8'h80);
                send_op(8'h00);
            end
            1: begin
                stream_end = "a spare or VFP opcode";
                do op = 8'($urandom);
                while (!(op == OP_SET_SP_R13 || op == OP_SET_SP_R15
                         || (op >= 8'hb3 && op <= 8'hc6) || op >= 8'hc8));
                send_op(op);
            end
            2: begin
                stream_end = "a bad second byte";
                send_op($urandom_range(1) ? OP_POP_LOW : OP_SPARE_C7);
                send_op($urandom_range(1) ? 8'h00 : {4'($urandom_range(15, 1)), 4'($urandom)});
            end
            3: begin
                stream_end = "an end inside a pop";
                send_op({5'b10101, 3'($urandom)});
                send_word($urandom);
                send_end();
            end
            4: begin
                stream_end = "an end after half an opcode";
                send_op({4'h8, 4'($urandom)});
                send_end();
            end
            default: begin
                stream_end = "a normal end";
                send_end();
            end
        endcase
        // Once stopped only loads change anything.
        repeat (12) begin
            case ($urandom_range(3))
                0: send_load(4'($urandom), edgy_word());
                1: send_op(8'($urandom));
                2: send_word($urandom);
                default: send_end();
            endcase
        end
    endtask

    initial begin : stimulus
        shadow       = new();
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        out_if.ready = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Light sender gaps, heavy back-pressure, with the directed opening.
        set_profile(13, 59, 1'b0);
        send_load(R_SP, 32'h0000_0010);
        send_load(R_LR, 32'h8000_1234);
        send_load(R_PC, 32'h0000_0000);
        send_load(R_FP, 32'hffff_ffff);
        // Largest and smallest vsp steps; the first one wraps below zero.
        send_op(8'h7f);
        send_op(8'h40);
        send_op(8'h3f);
        send_op(8'h00);
        send_op(OP_FINISH);
        send_op(8'h97);
        send_op(8'h00);
        send_op(OP_SP_ADD_LONG);
        send_op(8'hff);
        send_word($urandom);
        ignored_beats++;
        // Pop r4 and lr, with an opcode dropped in the middle.
        send_op(8'ha8);
        send_op(OP_FINISH);
        ignored_beats++;
        send_word(32'h0000_0044);
        send_word(32'hffff_fffe);
        // Pop vsp itself: it keeps the popped word.
        send_op(8'h82);
        send_op(8'h00);
        send_word(32'h0000_1000);
        send_op(OP_POP_LOW);
        send_op(8'h08);
        send_word(32'h1234_5678);
        send_op(OP_SPARE_C7);
        send_op(8'h0f);
        run_random(PHASE_ITEMS);
        drain();

        // Heavy sender gaps, light back-pressure.
        set_profile(59, 13, 1'b0);
        run_random(PHASE_ITEMS);
        drain();

        // Full rate, opened by one long receiver hold-off.
        set_profile(0, 0, 1'b1);
        run_random(PHASE_ITEMS);
        finish_stream();
        drain();
        repeat (8) @(posedge i_clk);

        $display("Covered %0d input beats and %0d result beats over three idle profiles;",
                 accepted_items, shadow.results_seen);
        $display("the opcode stream stopped on %s, %0d mismatches.", stream_end,
                 shadow.mismatches);
        if (shadow.mismatches == 0 && shadow.awaited.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule

// ===== stack_unwind_bytecode_executor.f =====
+incdir+rtl
rtl/sube_pkg.sv
rtl/sube_if.sv
rtl/sube_regfile.sv
rtl/sube_exec.sv
rtl/stack_unwind_bytecode_executor.sv
bench/testbench.sv
